// ===== rtl/pfe_pkg.sv =====
// pfe_pkg: shared constants and types for the printf format engine.
// No dependencies.
`default_nettype none
package pfe_pkg;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChLowC    = 8'h63;
  localparam logic [7:0] ChLowD    = 8'h64;
  localparam logic [7:0] ChLowU    = 8'h75;
  localparam logic [7:0] ChLowL    = 8'h6c;
  localparam logic [7:0] ChLowP    = 8'h70;

  localparam logic RegLimitEnable = 1'b0;
  localparam logic RegOutputLimit = 1'b1;

  typedef enum logic [2:0] {
    PsText      = 3'd0,
    PsEscape    = 3'd1,
    PsWidth     = 3'd2,
    PsPrecision = 3'd3,
    PsLong      = 3'd4
  } parse_e;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (ChZero + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction
endpackage
`default_nettype wire

// ===== rtl/printf_format_engine_core.sv =====
// printf_format_engine_core: top level of the printf format engine.
// Depends on pfe_pkg.
`default_nettype none
// Formats a printf-style string one format byte per input beat. A new beat is
// taken only once the previous item is finished. A numeric conversion first
// splits the value into digits and then streams the prefix, padding and digits
// one per cycle while the output is not stalled. Decimal digits come from a
// bit-serial divider (one argument bit per cycle). Hex digits are taken one
// nibble per cycle. The digit extraction loop sets the rate. Each output beat
// carries its buffer position; last marks the final stored beat of an input
// item. The end beat yields the terminator with the count.
module printf_format_engine_core #(
  parameter int DIGIT_BUFFER = 32,
  parameter int INDEX_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  format_char_i,
  input  wire logic [63:0] argument_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_char_o,
  output logic [15:0]      out_position_o,
  output logic             is_terminator_o,
  output logic             last_o
);
  import pfe_pkg::*;

  localparam int DW = $clog2(DIGIT_BUFFER + 1);
  localparam logic [INDEX_BITS-1:0] IdxMax = '1;

  typedef enum logic [2:0] {
    SIdle, SDiv, SPad, SDigit, SPre1, SPre2, SEmit
  } state_e;

  // Digit store: shift line, newest digit at entry 0. Drain it from entry 0,
  // most significant digit first.
  logic [3:0] dig_q [DIGIT_BUFFER];
  state_e st_q;
  parse_e ps_q;
  logic alt_q, zpad_q, wgiv_q, long_q, lim_en_q;
  logic [7:0] minw_q;
  logic [15:0] lim_q;
  logic [INDEX_BITS-1:0] widx_q;
  logic [63:0] quo_q;
  logic [3:0]  rem_q;
  logic [6:0]  bit_q;
  logic        hex_q;
  logic [DW-1:0] len_q, pad_q, cnt_q;
  logic [7:0]  pend_q;      // single char to emit in SEmit
  logic [1:0]  pre_q;       // 1 = '-', 2 = "0x" before number, 0 = none
  logic        num_q;       // number follows the prefix
  // Output register
  logic ov_q, oterm_q, olast_q;
  logic [7:0] ochar_q;
  logic [15:0] opos_q;

  wire in_fire  = in_valid_i && in_ready_o;
  wire out_free = !ov_q || out_ready_i;
  wire can_store = !(lim_en_q && ({{(32-INDEX_BITS){1'b0}}, widx_q} >= {16'd0, lim_q}))
                   && (widx_q != IdxMax);

  // Once a store fails, every later character of the item is dropped too, so
  // the beat stored just before that point is the final one.
  logic [INDEX_BITS-1:0] widx_nx;
  logic next_blk;
  assign widx_nx = widx_q + 1'b1;
  assign next_blk = (lim_en_q && (32'(widx_nx) >= 32'(lim_q))) || (widx_nx == IdxMax);

  assign in_ready_o = (st_q == SIdle) && out_free;
  assign out_valid_o = ov_q;
  assign out_char_o = ochar_q;
  assign out_position_o = opos_q;
  assign is_terminator_o = oterm_q;
  assign last_o = olast_q;

  logic is_dig;
  assign is_dig = (format_char_i >= ChZero) && (format_char_i <= ChNine);

  // Divider step: shift one dividend bit into the remainder.
  logic [4:0] rem_sh;
  logic [3:0] base_m;
  assign rem_sh = {rem_q, quo_q[63]};
  assign base_m = hex_q ? 4'd0 : 4'd10;
  logic rem_ge;
  assign rem_ge = hex_q ? 1'b0 : (rem_sh >= 5'd10);

  // Padding count from the width after prefix, capped so padding and digits fit the buffer.
  logic [DW-1:0] cap_w;
  logic [8:0] padn;
  assign padn = ({1'b0, minw_q} > 9'(len_q)) ? ({1'b0, minw_q} - 9'(len_q)) : 9'd0;
  assign cap_w = (9'(len_q) + padn > 9'(DIGIT_BUFFER)) ? DW'(DIGIT_BUFFER - int'(len_q))
                 : DW'(padn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ps_q <= PsText;
      alt_q <= 1'b0; zpad_q <= 1'b0; wgiv_q <= 1'b0; long_q <= 1'b0;
      minw_q <= '0; widx_q <= '0; lim_en_q <= 1'b0; lim_q <= '0;
      ov_q <= 1'b0; pre_q <= '0; num_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegLimitEnable) lim_en_q <= cfg_wdata_i[0];
        else lim_q <= cfg_wdata_i;
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          if (in_fire) begin
            if (op_i) begin
              ov_q <= 1'b1; ochar_q <= 8'd0; opos_q <= 16'(widx_q);
              oterm_q <= 1'b1; olast_q <= 1'b1;
              ps_q <= PsText; alt_q <= 1'b0; zpad_q <= 1'b0; wgiv_q <= 1'b0;
              long_q <= 1'b0; minw_q <= '0; widx_q <= '0;
            end else begin
              logic conv;
              conv = 1'b0;
              case (ps_q)
                PsText: begin
                  if (format_char_i == ChPercent) begin
                    alt_q <= 1'b0; zpad_q <= 1'b0; wgiv_q <= 1'b0;
                    long_q <= 1'b0; minw_q <= '0; ps_q <= PsEscape;
                  end else begin
                    pend_q <= format_char_i; pre_q <= '0; num_q <= 1'b0;
                    st_q <= SEmit;
                  end
                end
                PsEscape: begin
                  if (format_char_i == ChZero) zpad_q <= 1'b1;
                  else if (format_char_i == ChHash) alt_q <= 1'b1;
                  else if (is_dig) begin
                    wgiv_q <= 1'b1; minw_q <= format_char_i - ChZero; ps_q <= PsWidth;
                  end else if (format_char_i == ChDot) ps_q <= PsPrecision;
                  else conv = 1'b1;
                end
                PsWidth: begin
                  if (is_dig) begin
                    logic [11:0] nw;
                    nw = {minw_q, 3'b0} + {3'b0, minw_q, 1'b0}
                         + {4'd0, format_char_i - ChZero};
                    minw_q <= (nw > 12'd255) ? 8'd255 : nw[7:0];
                  end else if (format_char_i == ChDot) ps_q <= PsPrecision;
                  else conv = 1'b1;
                end
                PsPrecision: if (!is_dig) conv = 1'b1;
                PsLong: conv = 1'b1;
                default: ps_q <= PsText;
              endcase
              if (conv) begin
                logic [63:0] v;
                ps_q <= PsText;
                v = long_q ? argument_i : {32'd0, argument_i[31:0]};
                pre_q <= '0; len_q <= '0; rem_q <= '0; bit_q <= '0;
                hex_q <= 1'b0;
                case (format_char_i)
                  ChPercent: begin pend_q <= ChPercent; num_q <= 1'b0; st_q <= SEmit; end
                  ChLowC: begin pend_q <= argument_i[7:0]; num_q <= 1'b0; st_q <= SEmit; end
                  ChLowL: begin long_q <= 1'b1; ps_q <= PsLong; end
                  ChLowD: begin
                    if (!long_q) v = {{32{argument_i[31]}}, argument_i[31:0]};
                    if (v[63]) begin
                      v = 64'd0 - v; pre_q <= 2'd1;
                      minw_q <= (minw_q > 0) ? minw_q - 8'd1 : 8'd0;
                    end
                    quo_q <= v; num_q <= 1'b1; st_q <= SDiv;
                  end
                  ChLowU: begin quo_q <= v; num_q <= 1'b1; st_q <= SDiv; end
                  ChLowX, ChLowP: begin
                    if (format_char_i == ChLowP) v = argument_i;
                    quo_q <= v; hex_q <= 1'b1; num_q <= 1'b1; st_q <= SDiv;
                    if (alt_q || format_char_i == ChLowP) begin
                      pre_q <= 2'd2;
                      minw_q <= (minw_q > 8'd2) ? minw_q - 8'd2 : 8'd0;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        SDiv: begin
          // Decimal: restoring division, one bit per cycle.
          // Hex: take the low nibble straight from the shift line.
          if (hex_q) begin
            for (int i = DIGIT_BUFFER - 1; i > 0; i--) dig_q[i] <= dig_q[i-1];
            dig_q[0] <= quo_q[3:0];
            quo_q <= {4'd0, quo_q[63:4]};
            len_q <= len_q + 1'b1;
            if (quo_q[63:4] == '0 || int'(len_q) + 1 >= DIGIT_BUFFER) st_q <= SPad;
          end else begin
            quo_q <= {quo_q[62:0], rem_ge};
            rem_q <= rem_ge ? 4'(rem_sh - 5'(base_m)) : rem_sh[3:0];
            bit_q <= bit_q + 1'b1;
            if (bit_q == 7'd63) begin
              logic [63:0] q;
              q = {quo_q[62:0], rem_ge};
              for (int i = DIGIT_BUFFER - 1; i > 0; i--) dig_q[i] <= dig_q[i-1];
              dig_q[0] <= rem_ge ? 4'(rem_sh - 5'(base_m)) : rem_sh[3:0];
              len_q <= len_q + 1'b1; bit_q <= '0; rem_q <= '0;
              if (q == '0 || int'(len_q) + 1 >= DIGIT_BUFFER) st_q <= SPad;
            end
          end
        end
        SPad: begin
          pad_q <= wgiv_q ? cap_w : '0;
          cnt_q <= '0;
          st_q <= (pre_q != '0) ? SPre1 : SDigit;
        end
        SPre1, SPre2, SEmit, SDigit: begin
          if (out_free) begin
            logic [7:0] ch;
            logic fin;
            ch = pend_q; fin = 1'b1;
            if (st_q == SPre1) begin
              ch = (pre_q == 2'd1) ? ChMinus : ChZero;
              fin = 1'b0;
              st_q <= (pre_q == 2'd2) ? SPre2 : SDigit;
            end else if (st_q == SPre2) begin
              ch = ChLowX; fin = 1'b0; st_q <= SDigit;
            end else if (st_q == SDigit) begin
              if (cnt_q < pad_q) begin
                ch = zpad_q ? ChZero : ChSpace;
                fin = (len_q == '0) && (cnt_q + 1'b1 == pad_q);
                cnt_q <= cnt_q + 1'b1;
              end else begin
                ch = hex_char(dig_q[0]);
                fin = (len_q == DW'(1));
                len_q <= len_q - 1'b1;
                for (int i = 0; i < DIGIT_BUFFER - 1; i++) dig_q[i] <= dig_q[i+1];
              end
              if (fin) st_q <= SIdle;
            end else begin
              st_q <= SIdle;
            end
            if (can_store) begin
              ov_q <= 1'b1; ochar_q <= ch; opos_q <= 16'(widx_q);
              oterm_q <= 1'b0; olast_q <= fin || next_blk; widx_q <= widx_q + 1'b1;
            end
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // A terminator always closes a string, so position resets to zero after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i) |=> (widx_q == '0))
    else $error("write index not cleared after end beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oterm_q) |-> olast_q)
    else $error("terminator without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !in_ready_o)
    else $error("input taken while busy");
endmodule
`default_nettype wire

// ===== sim/tb_printf_format_engine_core.sv =====
// tb_printf_format_engine_core: self-checking testbench for the printf format engine.
// Depends on pfe_pkg and printf_format_engine_core.
`default_nettype none
module tb_printf_format_engine_core;
  import pfe_pkg::*;

  localparam logic OpChar = 1'b0;
  localparam logic OpEnd  = 1'b1;
  localparam int   PadCap = 32;
  // Longest quiet stretch: covers the digit work of a 64-bit %d.
  localparam int   SettleCycles = 1500;
  localparam logic [15:0] IndexMax = 16'hffff;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] pos;
    logic        term;
    logic        last;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = 1'b0;
  logic [7:0]  format_char_i = '0;
  logic [63:0] argument_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_char_o;
  logic [15:0] out_position_o;
  logic        is_terminator_o;
  logic        last_o;

  printf_format_engine_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .op_i, .format_char_i, .argument_i,
    .out_valid_o, .out_ready_i, .out_char_o, .out_position_o,
    .is_terminator_o, .last_o
  );

  always #6 clk_i = ~clk_i;

  // Expected output beats, oldest first.
  out_beat_t expected_chars[$];
  int unsigned mismatch_cnt = 0;

  // Idling controls shared by the stimulus and the receiver.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit rx_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Formatter state mirror
  // ---------------------------------------------------------------------------
  logic        lim_en;
  logic [15:0] lim_val;
  parse_e      pstate;
  bit          alt_f, zero_f, wid_f, long_f;
  int unsigned min_w;
  logic [15:0] widx;
  int          beats_this_item;

  function automatic void clear_escape();
    alt_f = 0; zero_f = 0; wid_f = 0; long_f = 0; min_w = 0;
  endfunction

  // Store one character unless the limit or the full index drops it.
  function automatic void store_char(logic [7:0] c);
    if (lim_en && widx >= lim_val) return;
    if (widx == IndexMax) return;
    expected_chars.push_back('{ch: c, pos: widx, term: 1'b0, last: 1'b0});
    widx++;
    beats_this_item++;
  endfunction

  function automatic void store_number(logic [63:0] v, int base, int w);
    string       digit_set = "0123456789abcdef";
    logic [7:0]  dig [PadCap];
    int          len = 0;
    int          pad = 0;
    do begin
      dig[len] = digit_set[v % base];
      len++;
      v = v / base;
    end while (v != 0 && len < PadCap);
    if (wid_f) begin
      while (len + pad < w && len + pad < PadCap) pad++;
    end
    for (int i = 0; i < pad; i++) store_char(zero_f ? ChZero : ChSpace);
    for (int i = len - 1; i >= 0; i--) store_char(dig[i]);
  endfunction

  function automatic void convert(logic [7:0] c, logic [63:0] arg);
    int          w = min_w;
    logic [63:0] v;
    pstate = PsText;
    case (c)
      ChPercent: store_char(ChPercent);
      ChLowC:    store_char(arg[7:0]);
      ChLowL: begin
        long_f = 1;
        pstate = PsLong;
      end
      ChLowD: begin
        v = long_f ? arg : {{32{arg[31]}}, arg[31:0]};
        if (v[63]) begin
          store_char(ChMinus);
          v = 64'd0 - v;
          w = (w > 0) ? w - 1 : 0;
        end
        store_number(v, 10, w);
      end
      ChLowU: store_number(long_f ? arg : {32'd0, arg[31:0]}, 10, w);
      ChLowX: begin
        if (alt_f) begin
          store_char(ChZero);
          store_char(ChLowX);
          w = (w > 2) ? w - 2 : 0;
        end
        store_number(long_f ? arg : {32'd0, arg[31:0]}, 16, w);
      end
      ChLowP: begin
        store_char(ChZero);
        store_char(ChLowX);
        w = (w > 2) ? w - 2 : 0;
        store_number(arg, 16, w);
      end
      default: ;
    endcase
    min_w = w;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  // Advance the mirror by one accepted input beat and queue what it yields.
  function automatic void predict_format(logic op, logic [7:0] c, logic [63:0] arg);
    int nw;
    beats_this_item = 0;
    if (op == OpEnd) begin
      expected_chars.push_back('{ch: 8'd0, pos: widx, term: 1'b1, last: 1'b0});
      beats_this_item = 1;
      pstate = PsText;
      clear_escape();
      widx = 0;
    end else begin
      case (pstate)
        PsText: begin
          if (c == ChPercent) begin
            clear_escape();
            pstate = PsEscape;
          end else begin
            store_char(c);
          end
        end
        PsEscape: begin
          if (c == ChZero) zero_f = 1;
          else if (c == ChHash) alt_f = 1;
          else if (is_digit(c)) begin
            wid_f = 1;
            min_w = c - ChZero;
            pstate = PsWidth;
          end else if (c == ChDot) pstate = PsPrecision;
          else convert(c, arg);
        end
        PsWidth: begin
          if (is_digit(c)) begin
            nw = min_w * 10 + (c - ChZero);
            min_w = (nw > 255) ? 255 : nw;
          end else if (c == ChDot) pstate = PsPrecision;
          else convert(c, arg);
        end
        PsPrecision: if (!is_digit(c)) convert(c, arg);
        PsLong: convert(c, arg);
        default: pstate = PsText;
      endcase
    end
    if (beats_this_item > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  bit rx_hold_req_q = 1'b0;
  int rx_hold_cnt = 0;
  int rx_gap_cnt = 0;

  always @(posedge clk_i) begin
    rx_hold_req_q <= rx_hold_req;
    if (rx_hold_req && !rx_hold_req_q) begin
      rx_hold_cnt <= 400;
      out_ready_i <= 1'b0;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idle && rx_gap_cnt > 0) begin
      rx_gap_cnt <= rx_gap_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_idle && $urandom_range(0, 5) == 0) rx_gap_cnt <= $urandom_range(1, 11);
    end
  end

  // Check each output beat mid-cycle; it is accepted at the coming rising edge.
  always @(negedge clk_i) begin
    out_beat_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{ch: out_char_o, pos: out_position_o, term: is_terminator_o, last: last_o};
      if (expected_chars.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: char %h pos %0d term %b last %b",
                   got.ch, got.pos, got.term, got.last);
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp char %h pos %0d term %b last %b / got %h %0d %b %b",
                     want.ch, want.pos, want.term, want.last,
                     got.ch, got.pos, got.term, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one beat; returns at the edge that accepted it, valid still high.
  task automatic send_beat(logic op, logic [7:0] c, logic [63:0] arg);
    int gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    format_char_i <= c;
    argument_i    <= arg;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_format(op, c, arg);
  endtask

  task automatic send_text(string s, logic [63:0] arg);
    for (int i = 0; i < s.len(); i++) send_beat(OpChar, s[i], arg);
  endtask

  task automatic send_end();
    send_beat(OpEnd, $urandom_range(0, 255), {$urandom, $urandom});
  endtask

  // Drop valid at once and wait until every expected beat has come, then let
  // trailing work finish so the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegLimitEnable) lim_en = val[0];
    else lim_val = val;
  endtask

  task automatic set_limit(logic en, logic [15:0] val);
    write_reg(RegLimitEnable, {15'd0, en});
    @(posedge clk_i);
    write_reg(RegOutputLimit, val);
  endtask

  function automatic logic [63:0] pick_arg();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {32'd0, $urandom};
      2: return $urandom_range(0, 999);
      3: return 64'h8000_0000_0000_0000;
      4: return {32'hffff_ffff, 32'h8000_0000};
      default: return ~64'd0 - $urandom_range(0, 99);
    endcase
  endfunction

  function automatic logic [7:0] pick_conv();
    case ($urandom_range(0, 9))
      0, 1: return ChLowD;
      2: return ChLowU;
      3, 4: return ChLowX;
      5: return ChLowP;
      6: return ChLowC;
      7: return ChPercent;
      8: return 8'h73;  // 's' is not supported
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // One escape with random flags, width, precision and length.
  task automatic send_escape();
    logic [63:0] arg = pick_arg();
    send_beat(OpChar, ChPercent, arg);
    repeat ($urandom_range(0, 2)) send_beat(OpChar, $urandom_range(0, 1) ? ChZero : ChHash, arg);
    if ($urandom_range(0, 1)) begin
      send_beat(OpChar, ChZero + $urandom_range(1, 9), arg);
      repeat ($urandom_range(0, 2)) send_beat(OpChar, ChZero + $urandom_range(0, 9), arg);
    end
    if ($urandom_range(0, 4) == 0) begin
      send_beat(OpChar, ChDot, arg);
      repeat ($urandom_range(0, 2)) send_beat(OpChar, ChZero + $urandom_range(0, 9), arg);
    end
    if ($urandom_range(0, 2) == 0) send_beat(OpChar, ChLowL, arg);
    // Now and then break the escape off with an end beat.
    if ($urandom_range(0, 19) == 0) send_end();
    else send_beat(OpChar, pick_conv(), arg);
  endtask

  task automatic send_random(int n_items);
    int sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_escape();
          sent += 5;
        end
        4: begin
          send_end();
          sent++;
        end
        5: begin
          send_beat(OpChar, $urandom_range(0, 255), {$urandom, $urandom});
          sent++;
        end
        default: begin
          send_beat(OpChar, $urandom_range(32, 126), {$urandom, $urandom});
          sent++;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_text("Hi", 64'd0);
    send_beat(OpChar, 8'h00, 64'd0);          // zero byte is an ordinary char
    send_beat(OpChar, 8'hff, 64'd0);
    send_text("%%", 64'd0);                   // percent escape returns to text
    send_text("%c", 64'hffff_ffff_ffff_ff41);
    send_text("%d", 64'h0000_0000_8000_0000); // most negative 32-bit value
    send_text("%ld", 64'h8000_0000_0000_0000);// most negative 64-bit value
    send_text("%lu", ~64'd0);
    send_text("%#010x", 64'h0000_0000_0000_beef);
    send_text("%lx", ~64'd0);
    send_text("%p", 64'd0);
    send_text("%999d", 64'd7);                // width saturates, field capped
    send_text("%5.3d", 64'hffff_ffff_ffff_fff6);
    send_text("%s", 64'd1);                   // unsupported conversion
    send_text("%0#", 64'd0);
    send_end();                               // end in the middle of an escape
    send_end();
  endtask

  task automatic test_limits();
    drain();
    set_limit(1'b1, 16'd0);
    send_text("ab%p", ~64'd0);
    send_end();
    drain();
    set_limit(1'b1, 16'd5);
    send_text("%032x", 64'h1234);
    send_end();
    drain();
    set_limit(1'b1, 16'hffff);
    send_text("%#x", 64'hab);
    send_end();
    drain();
    set_limit(1'b0, 16'd3);
  endtask

  task automatic test_backpressure();
    drain();
    tx_idle = 1;
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    repeat (40) send_beat(OpChar, $urandom_range(32, 126), 64'd0);
    send_text("%032lu", ~64'd0);
    rx_hold_req = 1'b0;
    send_end();
    // Pause the sender until everything is out.
    drain();
  endtask

  task automatic test_random();
    tx_idle = 1;
    rx_idle = 1;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_limit(1'b1, $urandom_range(0, 40));
        1: set_limit(1'b0, 16'hffff);
        2: set_limit(1'b1, $urandom_range(40, 65535));
        default: set_limit(1'b1, 16'd0);
      endcase
      send_random(40);
    end
    // Last stretch runs at full rate on both sides.
    drain();
    set_limit(1'b0, 16'd0);
    tx_idle = 0;
    rx_idle = 0;
    send_random(40);
    send_end();
  endtask

  initial begin
    lim_en = 0;
    lim_val = 0;
    pstate = PsText;
    clear_escape();
    widx = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
      $display("PASS printf_format_engine_core");
    end else begin
      $display("FAIL printf_format_engine_core");
    end
    $finish;
  end

  initial begin
    #(12 * 3_000_000);
    $display("FAIL printf_format_engine_core");
    $finish;
  end
endmodule
`default_nettype wire
